@@ rtl/bare_pkg.sv @@
// Shared types, constants and command/status bundles for the binary adaptive range encoder.
`timescale 1ns / 1ps

package bare_pkg;

    // Probability model
    localparam int          PROB_BITS  = 12;
    localparam int          PROB_SHIFT = 5;
    localparam int          CTX_BITS   = 8;
    localparam int          CTX_DEPTH  = 1 << CTX_BITS;
    localparam logic [PROB_BITS-1:0] PROB_HALF = PROB_BITS'(1 << (PROB_BITS - 1));
    localparam logic [PROB_BITS:0]   PROB_ONE  = (PROB_BITS + 1)'(1 << PROB_BITS);

    // Coder registers
    localparam int          RANGE_BITS = 32;
    localparam int          LOW_BITS   = 33;
    localparam logic [RANGE_BITS-1:0] RANGE_RESET = '1;

    // Pending run counter and its saturation limit
    localparam int          PENDING_BITS = 32;
    localparam int          COUNT_BITS   = 32;
    localparam logic [COUNT_BITS-1:0] PEND_LIMIT =
        (PENDING_BITS >= COUNT_BITS) ? '1 :
        COUNT_BITS'((64'd1 << PENDING_BITS) - 64'd1);

    // Results per item; shifting stops once this many results exist
    localparam int          NRES_BITS    = 5;
    localparam logic [NRES_BITS-1:0] NRES_SHIFT_MAX = NRES_BITS'(15);

    // Input item kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_UPD,
        S_RENORM,
        S_SH_FIRST,
        S_SH_RUN,
        S_FIN_FIRST,
        S_FIN_RUN,
        S_FIN_LOW,
        S_CLOSE
    } t_state;

    typedef enum logic [1:0] {
        EM_FIRST,
        EM_RUN,
        EM_LOW
    } t_emit_sel;

    typedef struct packed {
        logic       load;
        logic       mul;
        logic       upd;
        logic       shift;
        logic       emit;
        t_emit_sel  emit_sel;
        logic [1:0] low_idx;
        logic       close;
        logic       clear;
    } t_dp_cmd;

    typedef struct packed {
        logic emit_ok;
        logic range_small;
        logic shift_cond;
        logic run_nz;
    } t_dp_sts;

endpackage

@@ rtl/bare_dp.sv @@
// Datapath: probability memory, coder registers, carry/pending logic and result staging.
`timescale 1ns / 1ps

module bare_dp import bare_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_in_byte,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [7:0]            o_out_byte,
    output logic [31:0]           o_repeat_res,
    output logic                  o_last
);

    // Probability memory and its valid bits
    logic [PROB_BITS-1:0]  r_mem [CTX_DEPTH];
    logic [CTX_DEPTH-1:0]  r_pvalid;
    logic [PROB_BITS-1:0]  r_prob_q;
    logic                  r_pv;

    // Symbol walk
    logic [CTX_BITS-1:0]   r_ctx;
    logic [7:0]            r_sym;

    // Multiply stage
    logic [PROB_BITS-1:0]  r_p;
    logic [RANGE_BITS-1:0] r_mid;

    // Coder state
    logic [LOW_BITS-1:0]   r_low,   n_low;
    logic [RANGE_BITS-1:0] r_range, n_range;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [7:0]            r_first, n_first;

    // Result staging and output
    logic                  r_stg_valid;
    logic [7:0]            r_stg_byte;
    logic [31:0]           r_stg_rep;
    logic                  r_out_valid;
    logic [7:0]            r_out_byte;
    logic [31:0]           r_out_rep;
    logic                  r_out_last;

    logic [PROB_BITS-1:0]  w_p_eff;
    logic [RANGE_BITS-1:0] w_prod;
    logic                  w_bit;
    logic [PROB_BITS:0]    w_gap;
    logic [PROB_BITS-1:0]  w_pnew;
    logic                  w_carry;
    logic [31:0]           w_lo32;
    logic                  w_out_free;
    logic [7:0]            w_em_byte;
    logic [31:0]           w_em_rep;

    assign w_p_eff = r_pv ? r_prob_q : PROB_HALF;
    assign w_prod  = {{(RANGE_BITS-(RANGE_BITS-PROB_BITS)){1'b0}}, r_range[RANGE_BITS-1:PROB_BITS]}
                   * {{(RANGE_BITS-PROB_BITS){1'b0}}, w_p_eff};
    assign w_bit   = r_sym[7];
    assign w_gap   = (PROB_ONE - {1'b0, r_p}) >> PROB_SHIFT;
    assign w_pnew  = w_bit ? (r_p + w_gap[PROB_BITS-1:0]) : (r_p - (r_p >> PROB_SHIFT));
    assign w_carry = r_low[LOW_BITS-1];
    assign w_lo32  = r_low[31:0];

    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_sts.emit_ok     = !r_stg_valid || w_out_free;
    assign o_sts.range_small = (r_range[31:24] == 8'h00);
    assign o_sts.shift_cond  = (w_lo32[31:24] != 8'hFF) || w_carry;
    assign o_sts.run_nz      = (r_count > 32'd1);

    // Memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_mem[r_ctx] <= w_pnew;
        end
        r_prob_q <= r_mem[r_ctx];
        r_pv     <= r_pvalid[r_ctx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_pvalid <= '0;
        end else if (i_cmd.upd) begin
            r_pvalid[r_ctx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ctx <= CTX_BITS'(1);
            r_sym <= i_in_byte;
        end else if (i_cmd.upd) begin
            r_ctx <= {r_ctx[CTX_BITS-2:0], w_bit};
            r_sym <= {r_sym[6:0], 1'b0};
        end
        if (i_cmd.mul) begin
            r_p   <= w_p_eff;
            r_mid <= w_prod;
        end
    end

    always_comb begin
        n_low   = r_low;
        n_range = r_range;
        n_count = r_count;
        n_first = r_first;
        if (i_cmd.upd) begin
            if (w_bit) begin
                n_range = r_mid;
            end else begin
                n_low   = r_low + {1'b0, r_mid};
                n_range = r_range - r_mid;
            end
        end
        if (i_cmd.shift) begin
            if (o_sts.shift_cond) begin
                n_count = COUNT_BITS'(1);
                n_first = w_lo32[31:24];
            end else if (r_count < PEND_LIMIT) begin
                n_count = r_count + COUNT_BITS'(1);
            end
            n_low   = {1'b0, w_lo32[23:0], 8'h00};
            n_range = {r_range[23:0], 8'h00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_low   <= '0;
            r_range <= RANGE_RESET;
            r_count <= COUNT_BITS'(1);
            r_first <= '0;
        end else begin
            r_low   <= n_low;
            r_range <= n_range;
            r_count <= n_count;
            r_first <= n_first;
        end
    end

    // Result value for the selected emission
    always_comb begin
        w_em_byte = r_first + {7'd0, w_carry};
        w_em_rep  = 32'd1;
        unique case (i_cmd.emit_sel)
            EM_FIRST: begin
                w_em_byte = r_first + {7'd0, w_carry};
            end
            EM_RUN: begin
                w_em_byte = w_carry ? 8'h00 : 8'hFF;
                w_em_rep  = r_count - 32'd1;
            end
            EM_LOW: begin
                unique case (i_cmd.low_idx)
                    2'd0:    w_em_byte = w_lo32[31:24];
                    2'd1:    w_em_byte = w_lo32[23:16];
                    2'd2:    w_em_byte = w_lo32[15:8];
                    default: w_em_byte = w_lo32[7:0];
                endcase
            end
            default: begin
                w_em_byte = r_first + {7'd0, w_carry};
            end
        endcase
    end

    // Stage one result so the item's final result can be marked last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if ((i_cmd.emit || i_cmd.close) && r_stg_valid) begin
                r_out_valid <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_stg_valid <= 1'b1;
            end else if (i_cmd.close) begin
                r_stg_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.emit || i_cmd.close) && r_stg_valid) begin
            r_out_byte <= r_stg_byte;
            r_out_rep  <= r_stg_rep;
            r_out_last <= i_cmd.close;
        end
        if (i_cmd.emit) begin
            r_stg_byte <= w_em_byte;
            r_stg_rep  <= w_em_rep;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_repeat_res = r_out_rep;
    assign o_last       = r_out_last;

endmodule

@@ rtl/bare_ctrl.sv @@
// Controller: sequences bit coding, renormalization, flushing and result emission.
`timescale 1ns / 1ps

module bare_ctrl import bare_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_kind,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state                r_state, n_state;
    logic [2:0]            r_bitcnt, n_bitcnt;
    logic [1:0]            r_lowk, n_lowk;
    logic [NRES_BITS-1:0]  r_nres, n_nres;
    logic                  r_fin, n_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bitcnt <= '0;
            r_lowk   <= '0;
            r_nres   <= '0;
            r_fin    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bitcnt <= n_bitcnt;
            r_lowk   <= n_lowk;
            r_nres   <= n_nres;
            r_fin    <= n_fin;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_bitcnt = r_bitcnt;
        n_lowk   = r_lowk;
        n_nres   = r_nres;
        n_fin    = r_fin;
        o_cmd    = '0;
        o_cmd.emit_sel = EM_FIRST;
        o_cmd.low_idx  = r_lowk;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_bitcnt   = '0;
                    n_lowk     = '0;
                    n_nres     = '0;
                    n_fin      = i_kind;
                    n_state    = (i_kind == KIND_FINISH) ? S_FIN_FIRST : S_READ;
                end
            end
            S_READ: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_RENORM;
            end
            S_RENORM: begin
                if (i_sts.range_small && r_nres < NRES_SHIFT_MAX) begin
                    if (i_sts.shift_cond) begin
                        n_state = S_SH_FIRST;
                    end else begin
                        o_cmd.shift = 1'b1;
                    end
                end else if (r_bitcnt == 3'd7) begin
                    n_state = S_CLOSE;
                end else begin
                    n_bitcnt = r_bitcnt + 3'd1;
                    n_state  = S_MUL;
                end
            end
            S_SH_FIRST: begin
                if (i_sts.emit_ok) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EM_FIRST;
                    n_nres         = r_nres + NRES_BITS'(1);
                    if (i_sts.run_nz) begin
                        n_state = S_SH_RUN;
                    end else begin
                        o_cmd.shift = 1'b1;
                        n_state     = S_RENORM;
                    end
                end
            end
            S_SH_RUN: begin
                if (i_sts.emit_ok) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EM_RUN;
                    o_cmd.shift    = 1'b1;
                    n_nres         = r_nres + NRES_BITS'(1);
                    n_state        = S_RENORM;
                end
            end
            S_FIN_FIRST: begin
                if (i_sts.emit_ok) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EM_FIRST;
                    n_state        = i_sts.run_nz ? S_FIN_RUN : S_FIN_LOW;
                end
            end
            S_FIN_RUN: begin
                if (i_sts.emit_ok) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EM_RUN;
                    n_state        = S_FIN_LOW;
                end
            end
            S_FIN_LOW: begin
                if (i_sts.emit_ok) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EM_LOW;
                    n_lowk         = r_lowk + 2'd1;
                    if (r_lowk == 2'd3) begin
                        n_state = S_CLOSE;
                    end
                end
            end
            S_CLOSE: begin
                if (i_sts.emit_ok) begin
                    o_cmd.close = 1'b1;
                    o_cmd.clear = r_fin;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ rtl/binary_adaptive_range_encoder.sv @@
// Top level: adaptive bitwise range encoder, one byte or finish command per item.
// Sequence: a data item is accepted, reads the table, then for each of its 8 bits runs
//   multiply, coder update and renormalize, then closes; output stall can extend it.
// Throughput: one item at a time; the per-bit loop of table read, multiply and coder
//   update sets the rate. A finish item flushes the four low bytes, then closes.
// Reset: i_rst_n is synchronous, active low; clears control, coder registers and the
//   probability valid bits at once (every context reads as one half). No clearing pass.
`timescale 1ns / 1ps

module binary_adaptive_range_encoder import bare_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_in_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic [31:0] o_repeat_res,
    output logic        o_last
);

    // Command and status bundles between sequencer and datapath
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer: walks the 8 bits, runs renormalization one byte shift per cycle while
    // no result is emitted, emits the carry-resolved first byte and the pending 0xFF run,
    // and on finish flushes the four low bytes and clears the model.
    bare_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // Datapath: probability memory with registered read, 20x12 multiply,
    // low/range/pending registers, and a one-deep staging register in front of the
    // output register so the final result of each item can carry the last flag
    // while the next result is being formed.
    bare_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_byte    (i_in_byte),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_repeat_res (o_repeat_res),
        .o_last       (o_last)
    );

endmodule
